FILE: src/drtp_pkg.sv
// Package for the dependency ready task picker: shared types and codes.
// No dependencies.
`default_nettype none
package drtp_pkg;
   typedef enum logic [1:0] {
      OP_ADD      = 2'd0,
      OP_COMPLETE = 2'd1,
      OP_CLEAR    = 2'd2,
      OP_NONE     = 2'd3
   } opcode_type;

   typedef enum logic [1:0] {
      ST_PENDING  = 2'd0,
      ST_COMPLETE = 2'd1,
      ST_FAILED   = 2'd2,
      ST_UNUSED   = 2'd3
   } slot_status_type;

   typedef enum logic [1:0] {
      RES_OK        = 2'd0,
      RES_FULL      = 2'd1,
      RES_NOT_FOUND = 2'd2,
      RES_UNUSED    = 2'd3
   } op_status_type;

   typedef enum logic [1:0] {
      PLAN_ACTIVE   = 2'd0,
      PLAN_COMPLETE = 2'd1,
      PLAN_FAILED   = 2'd2,
      PLAN_UNUSED   = 2'd3
   } plan_type;

   typedef enum logic [1:0] {
      FSM_IDLE  = 2'd0,
      FSM_EXEC  = 2'd1,
      FSM_EVAL  = 2'd2,
      FSM_SCAN  = 2'd3
   } fsm_type;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic capture;
      logic exec;
      logic eval;
      logic scan;
   } cmd_type;
endpackage
`default_nettype wire

FILE: src/drtp_datapath.sv
// Datapath of the ready task picker: task table, matching and selection.
// Depends on drtp_pkg; commanded by drtp_ctrl.
`default_nettype none
module drtp_datapath #(
   parameter int TASK_SLOTS = 16,
   parameter int MAX_DEPS   = 4,
   parameter int ID_BITS    = 8
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire drtp_pkg::cmd_type    cmd,
   input  wire logic [1:0]           in_opcode,
   input  wire logic [ID_BITS-1:0]   in_ident,
   input  wire logic [1:0]           in_priority,
   input  wire logic [2:0]           in_dep_total,
   input  wire logic [4*ID_BITS-1:0] in_dep_ids,
   input  wire logic                 in_succeeded,
   output logic [1:0]                op_status,
   output logic                      ready_valid,
   output logic [7:0]                ready_ident,
   output logic [1:0]                ready_priority,
   output logic [1:0]                plan_state,
   output logic [4:0]                tasks_held
);
   import drtp_pkg::*;

   localparam int IW = $clog2(TASK_SLOTS);
   localparam int CW = $clog2(TASK_SLOTS + 1);
   localparam int DF = (MAX_DEPS < 4) ? MAX_DEPS : 4;
   localparam int DW = $clog2(MAX_DEPS + 1);

   logic [ID_BITS-1:0]  slot_ident_ff  [TASK_SLOTS];
   logic [1:0]          slot_prio_ff   [TASK_SLOTS];
   slot_status_type     slot_status_ff [TASK_SLOTS];
   logic [ID_BITS-1:0]  slot_deps_ff   [TASK_SLOTS][MAX_DEPS];
   logic [DW-1:0]       slot_dtot_ff   [TASK_SLOTS];
   logic [CW-1:0]       total_ff, total_in;
   plan_type            plan_ff, plan_in;

   // Captured request word.
   logic [1:0]           op_ff;
   logic [ID_BITS-1:0]   id_ff;
   logic [1:0]           prio_ff;
   logic [DW-1:0]        dtot_ff;
   logic [ID_BITS-1:0]   deps_ff [MAX_DEPS];
   logic                 succ_ff;
   op_status_type        res_ff;

   // Response word registers.
   logic [1:0]           status_out_ff;
   logic                 valid_out_ff;
   logic [7:0]           ident_out_ff;
   logic [1:0]           prio_out_ff;
   logic [1:0]           plan_out_ff;
   logic [4:0]           held_out_ff;

   logic [TASK_SLOTS-1:0] live, hit, done_vec, pend_vec, fail_vec, ready_vec;
   logic [IW-1:0]         first_hit;
   logic                  any_hit;
   logic                  pick_have;
   logic [1:0]            pick_prio;
   logic [ID_BITS-1:0]    pick_ident;

   always_comb begin
      for (int i = 0; i < TASK_SLOTS; i++) begin
         live[i]     = CW'(i) < total_ff;
         hit[i]      = live[i] && slot_ident_ff[i] == id_ff;
         done_vec[i] = live[i] && slot_status_ff[i] == ST_COMPLETE;
         pend_vec[i] = live[i] && slot_status_ff[i] == ST_PENDING;
         fail_vec[i] = live[i] && slot_status_ff[i] == ST_FAILED;
      end
      any_hit   = |hit;
      first_hit = '0;
      for (int i = TASK_SLOTS - 1; i >= 0; i--) begin
         if (hit[i]) begin
            first_hit = IW'(i);
         end
      end
   end

   // Parallel dependency match against completed slots.
   always_comb begin
      logic met, found;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         met = pend_vec[i];
         for (int d = 0; d < MAX_DEPS; d++) begin
            found = 1'b0;
            for (int j = 0; j < TASK_SLOTS; j++) begin
               found = found | (done_vec[j] && slot_ident_ff[j] == slot_deps_ff[i][d]);
            end
            if (DW'(d) < slot_dtot_ff[i] && !found) begin
               met = 1'b0;
            end
         end
         ready_vec[i] = met;
      end
   end

   always_comb begin
      total_in = total_ff;
      plan_in  = plan_ff;
      if (cmd.exec) begin
         unique case (opcode_type'(op_ff))
            OP_ADD:      if (total_ff < CW'(TASK_SLOTS)) total_in = total_ff + 1'b1;
            OP_CLEAR: begin
               total_in = '0;
               plan_in  = PLAN_ACTIVE;
            end
            OP_COMPLETE, OP_NONE: ;
            default: ;
         endcase
      end
      if (cmd.eval && opcode_type'(op_ff) == OP_COMPLETE && res_ff == RES_OK
          && pend_vec == '0) begin
         plan_in = (fail_vec != '0) ? PLAN_FAILED : PLAN_COMPLETE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         total_ff <= '0;
         plan_ff  <= PLAN_ACTIVE;
      end else begin
         total_ff <= total_in;
         plan_ff  <= plan_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff   <= in_opcode;
         id_ff   <= in_ident;
         prio_ff <= in_priority;
         dtot_ff <= (in_dep_total > 3'(DF)) ? DW'(DF) : DW'(in_dep_total);
         succ_ff <= in_succeeded;
         for (int d = 0; d < MAX_DEPS; d++) begin
            deps_ff[d] <= (d < 4) ? in_dep_ids[(d%4)*ID_BITS +: ID_BITS] : '0;
         end
      end
      if (cmd.exec) begin
         res_ff <= RES_OK;
         if (opcode_type'(op_ff) == OP_ADD) begin
            if (total_ff >= CW'(TASK_SLOTS)) begin
               res_ff <= RES_FULL;
            end else begin
               slot_ident_ff[total_ff[IW-1:0]]  <= id_ff;
               slot_prio_ff[total_ff[IW-1:0]]   <= prio_ff;
               slot_status_ff[total_ff[IW-1:0]] <= ST_PENDING;
               slot_dtot_ff[total_ff[IW-1:0]]   <= dtot_ff;
               for (int d = 0; d < MAX_DEPS; d++) begin
                  slot_deps_ff[total_ff[IW-1:0]][d] <= deps_ff[d];
               end
            end
         end else if (opcode_type'(op_ff) == OP_COMPLETE) begin
            if (any_hit) begin
               slot_status_ff[first_hit] <= succ_ff ? ST_COMPLETE : ST_FAILED;
            end else begin
               res_ff <= RES_NOT_FOUND;
            end
         end
      end
   end

   // Priority pick: highest priority, lowest slot on ties.
   always_comb begin
      pick_have  = 1'b0;
      pick_prio  = '0;
      pick_ident = '0;
      for (int i = 0; i < TASK_SLOTS; i++) begin
         if (ready_vec[i] && (!pick_have || slot_prio_ff[i] > pick_prio)) begin
            pick_have  = 1'b1;
            pick_prio  = slot_prio_ff[i];
            pick_ident = slot_ident_ff[i];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan) begin
         status_out_ff <= res_ff;
         valid_out_ff  <= pick_have;
         ident_out_ff  <= 8'(pick_ident);
         prio_out_ff   <= pick_prio;
         plan_out_ff   <= plan_ff;
         held_out_ff   <= 5'(total_ff);
      end
   end

   assign op_status      = status_out_ff;
   assign ready_valid    = valid_out_ff;
   assign ready_ident    = ident_out_ff;
   assign ready_priority = prio_out_ff;
   assign plan_state     = plan_out_ff;
   assign tasks_held     = held_out_ff;
endmodule
`default_nettype wire

FILE: src/drtp_ctrl.sv
// Controller of the ready task picker: sequences capture, update, evaluation, pick.
// Depends on drtp_pkg.
`default_nettype none
module drtp_ctrl (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output drtp_pkg::cmd_type      cmd
);
   import drtp_pkg::*;

   fsm_type state_ff, state_in;
   logic    rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         FSM_IDLE: if (req_valid && !req_stall) state_in = FSM_EXEC;
         FSM_EXEC: state_in = FSM_EVAL;
         FSM_EVAL: state_in = FSM_SCAN;
         FSM_SCAN: state_in = FSM_IDLE;
         default:  state_in = FSM_IDLE;
      endcase
   end

   always_comb begin
      req_stall   = state_ff != FSM_IDLE || (rsp_valid_ff && rsp_stall);
      cmd.capture = state_ff == FSM_IDLE && req_valid && !req_stall;
      cmd.exec    = state_ff == FSM_EXEC;
      cmd.eval    = state_ff == FSM_EVAL;
      cmd.scan    = state_ff == FSM_SCAN;
      rsp_valid_in = rsp_valid_ff;
      if (rsp_valid_ff && !rsp_stall) rsp_valid_in = 1'b0;
      if (cmd.scan) rsp_valid_in = 1'b1;
      rsp_valid = rsp_valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= FSM_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

`ifndef SYNTHESIS
   a_one_in_flight: assert property (@(posedge clock) disable iff (reset)
      cmd.capture |=> cmd.exec ##1 cmd.eval ##1 cmd.scan) else $error("sequence broken");
   a_no_lost_rsp: assert property (@(posedge clock) disable iff (reset)
      cmd.scan |-> !(rsp_valid_ff && rsp_stall)) else $error("result overwritten");
   a_stall_busy: assert property (@(posedge clock) disable iff (reset)
      state_ff != FSM_IDLE |-> req_stall) else $error("accept while busy");
`endif
endmodule
`default_nettype wire

FILE: src/dependency_ready_task_picker.sv
// Top level of the dependency ready task picker.
// Depends on drtp_pkg, drtp_ctrl and drtp_datapath.
`default_nettype none
// Each request word passes through capture, table update, plan evaluation
// and ready task pick, set by the controller sequence over one shared table.
// The next word is taken once the result register is free. The
// dependency match compares every stored dependency id with every stored task id in parallel.
module dependency_ready_task_picker #(
   parameter int TASK_SLOTS = 16,
   parameter int MAX_DEPS   = 4,
   parameter int ID_BITS    = 8
) (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic [1:0]         req_opcode,
   input  wire logic [ID_BITS-1:0] req_task_ident,
   input  wire logic [1:0]         req_task_priority,
   input  wire logic [2:0]         req_dep_total,
   input  wire logic [ID_BITS-1:0] req_dep_id_0,
   input  wire logic [ID_BITS-1:0] req_dep_id_1,
   input  wire logic [ID_BITS-1:0] req_dep_id_2,
   input  wire logic [ID_BITS-1:0] req_dep_id_3,
   input  wire logic               req_succeeded,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [1:0]              rsp_op_status,
   output logic                    rsp_ready_valid,
   output logic [7:0]              rsp_ready_task_ident,
   output logic [1:0]              rsp_ready_priority,
   output logic [1:0]              rsp_plan_state,
   output logic [4:0]              rsp_tasks_held
);
   import drtp_pkg::*;

   cmd_type cmd;

   drtp_ctrl u_ctrl (
      .clock, .reset, .req_valid, .req_stall, .rsp_valid, .rsp_stall, .cmd
   );

   drtp_datapath #(.TASK_SLOTS(TASK_SLOTS), .MAX_DEPS(MAX_DEPS), .ID_BITS(ID_BITS)) u_dp (
      .clock, .reset, .cmd,
      .in_opcode(req_opcode),
      .in_ident(req_task_ident),
      .in_priority(req_task_priority),
      .in_dep_total(req_dep_total),
      .in_dep_ids({req_dep_id_3, req_dep_id_2, req_dep_id_1, req_dep_id_0}),
      .in_succeeded(req_succeeded),
      .op_status(rsp_op_status),
      .ready_valid(rsp_ready_valid),
      .ready_ident(rsp_ready_task_ident),
      .ready_priority(rsp_ready_priority),
      .plan_state(rsp_plan_state),
      .tasks_held(rsp_tasks_held)
   );
endmodule
`default_nettype wire
